/* sv/tdhc_pkg.sv */
`default_nettype none

package tdhc_pkg;

  // Widths of the word fields
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned SLOT_W   = 4;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD      = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CHECK    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_COMPLETE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RESTART  = 3'd4;

  // Dependence kinds; any code other than in acts as a writer
  localparam logic [KIND_W-1:0] KIND_IN    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OUT   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INOUT = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KIND_W-1:0]   dep_kind;
    logic [ADDR_W-1:0]   dep_addr;
    logic [SLOT_W-1:0]   pred_slot;
  } req_t;

  typedef struct packed {
    logic conflict;
    logic ready_res;
    logic table_full;
  } rsp_t;

endpackage

`default_nettype wire

/* sv/tdhc_ram.sv */
`default_nettype none

module tdhc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/task_dependence_hazard_checker_top.sv */
`default_nettype none

// Channel | valid     | stall     | word            | direction
// --------+-----------+-----------+-----------------+----------
// req     | req_valid | req_stall | tdhc_pkg::req_t | into block
// rsp     | rsp_valid | rsp_stall | tdhc_pkg::rsp_t | out of block
//
// Clear, add, complete, restart and spare words need no scan: the result word is
// loaded into the output register at the edge that accepts the request. A check walks
// the own table (RAM, registered read) one entry per cycle through one comparator,
// then waits in FIN until the output register is free to take the result word.
// rst is synchronous and clears the count, the wait mask and the done flags.
// req_stall is high while a check runs or while a result word waits under rsp_stall.

module task_dependence_hazard_checker_top #(
  parameter int unsigned OWN_DEPS   = 16,
  parameter int unsigned PRED_SLOTS = 16,
  parameter int unsigned ADDR_BITS  = 48
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire tdhc_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output tdhc_pkg::rsp_t      rsp
);

  // Compared address bits: the word carries at most ADDR_W of them
  localparam int unsigned AW = (ADDR_BITS < tdhc_pkg::ADDR_W) ? ADDR_BITS : tdhc_pkg::ADDR_W;
  localparam int unsigned EW = AW + tdhc_pkg::KIND_W;
  localparam int unsigned IW = (OWN_DEPS > 1) ? $clog2(OWN_DEPS) : 1;
  localparam int unsigned CW = $clog2(OWN_DEPS + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FIN
  } state_t;

  state_t                      state;
  logic [CW-1:0]               own_count;
  logic [PRED_SLOTS-1:0]       wait_mask;
  logic [PRED_SLOTS-1:0]       done_flags;

  // Latched check request
  logic [AW-1:0]               cur_addr;
  logic [tdhc_pkg::KIND_W-1:0] cur_kind;
  logic [tdhc_pkg::SLOT_W-1:0] cur_slot;

  // Scan sequencer: ptr issues reads, pend marks valid read data, hit collects
  logic [CW-1:0]               ptr;
  logic                        pend;
  logic                        hit;

  logic                        req_acc;
  logic                        out_free;
  logic                        scan_more;
  logic                        entry_hit;
  logic [tdhc_pkg::SLOT_W-1:0] dec_slot;
  logic [PRED_SLOTS-1:0]       slot_dec;

  logic                        ram_we;
  logic [EW-1:0]               ram_rdata;
  logic [AW-1:0]               rd_addr;
  logic [tdhc_pkg::KIND_W-1:0] rd_kind;

  logic [CW-1:0]               count_next;
  logic [PRED_SLOTS-1:0]       mask_next;
  logic [PRED_SLOTS-1:0]       done_next;
  logic                        full_next;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != IDLE) || !out_free;
  assign req_acc   = req_valid && !req_stall;

  // Append at the current count while room is left
  assign ram_we = req_acc && (req.action == tdhc_pkg::ACT_ADD) && (own_count < CW'(OWN_DEPS));

  tdhc_ram #(
    .WIDTH(EW),
    .DEPTH(OWN_DEPS)
  ) u_own_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(own_count[IW-1:0]),
    .wdata({req.dep_kind, req.dep_addr[AW-1:0]}),
    .raddr(ptr[IW-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_addr = ram_rdata[AW-1:0];
  assign rd_kind = ram_rdata[EW-1:AW];

  // One comparator: a read-read pair is the only pair that never conflicts
  assign scan_more = ptr < own_count;
  assign entry_hit = pend && (rd_addr == cur_addr) &&
                     !((rd_kind == tdhc_pkg::KIND_IN) && (cur_kind == tdhc_pkg::KIND_IN));

  // Slot decode; slots at or beyond PRED_SLOTS decode to nothing
  assign dec_slot = (state == IDLE) ? req.pred_slot : cur_slot;

  always_comb begin
    for (int i = 0; i < PRED_SLOTS; i++) begin
      slot_dec[i] = (32'(dec_slot) == 32'(i));
    end
  end

  // Next state of the actions other than a check
  always_comb begin
    count_next = own_count;
    mask_next  = wait_mask;
    done_next  = done_flags;
    full_next  = 1'b0;
    case (req.action)
      tdhc_pkg::ACT_CLEAR: begin
        count_next = '0;
        mask_next  = '0;
      end
      tdhc_pkg::ACT_ADD: begin
        if (own_count < CW'(OWN_DEPS)) begin
          count_next = own_count + CW'(1);
        end else begin
          full_next = 1'b1;
        end
      end
      tdhc_pkg::ACT_COMPLETE: done_next = done_flags | slot_dec;
      tdhc_pkg::ACT_RESTART:  done_next = done_flags & ~slot_dec;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      own_count  <= '0;
      wait_mask  <= '0;
      done_flags <= '0;
      rsp_valid  <= 1'b0;
      ptr        <= '0;
      pend       <= 1'b0;
      hit        <= 1'b0;
    end else begin
      // Drop the result word once taken
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_acc) begin
            cur_addr <= req.dep_addr[AW-1:0];
            cur_kind <= req.dep_kind;
            cur_slot <= req.pred_slot;
            ptr      <= '0;
            pend     <= 1'b0;
            hit      <= 1'b0;
            if (req.action == tdhc_pkg::ACT_CHECK) begin
              state <= SCAN;
            end else begin
              own_count      <= count_next;
              wait_mask      <= mask_next;
              done_flags     <= done_next;
              rsp_valid      <= 1'b1;
              rsp.conflict   <= 1'b0;
              rsp.ready_res  <= ((mask_next & ~done_next) == '0);
              rsp.table_full <= full_next;
            end
          end
        end
        SCAN: begin
          // Issue the next read, compare the one that came back
          if (scan_more) begin
            ptr  <= ptr + CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (entry_hit) begin
            hit <= 1'b1;
          end
          if (!scan_more && !pend) begin
            if (hit) begin
              wait_mask <= wait_mask | slot_dec;
            end
            state <= FIN;
          end
        end
        FIN: begin
          // Hold until the output register is free
          if (out_free) begin
            rsp_valid      <= 1'b1;
            rsp.conflict   <= hit;
            rsp.ready_res  <= ((wait_mask & ~done_flags) == '0);
            rsp.table_full <= 1'b0;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> (ptr <= own_count))
    else $error("scan pointer passed the entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    own_count <= CW'(OWN_DEPS))
    else $error("entry count exceeds table depth");

  a_fast_result: assert property (@(posedge clk) disable iff (rst)
    (req_acc && (req.action != tdhc_pkg::ACT_CHECK)) |=> rsp_valid)
    else $error("one-cycle action produced no result word");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.conflict && rsp.table_full))
    else $error("conflict and table_full both set");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !req_acc)
    else $error("request accepted during a check");

endmodule

`default_nettype wire

/* sim/tdhc_checker.sv */
module tdhc_checker #(
  parameter int unsigned OWN_DEPS   = 16,
  parameter int unsigned PRED_SLOTS = 16,
  parameter int unsigned ADDR_BITS  = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  tdhc_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  tdhc_pkg::rsp_t rsp,
  output int unsigned    fail_count,
  output int unsigned    words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tdhc_pkg::ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= tdhc_pkg::ADDR_W) ? {tdhc_pkg::ADDR_W{1'b1}} :
    ({tdhc_pkg::ADDR_W{1'b1}} >> (tdhc_pkg::ADDR_W - ADDR_BITS));
  localparam int unsigned IW = (OWN_DEPS > 1) ? $clog2(OWN_DEPS) : 1;

  // Shadow of the own dependence table and the slot bookkeeping
  logic [tdhc_pkg::ADDR_W-1:0] own_addr [OWN_DEPS];
  logic [tdhc_pkg::KIND_W-1:0] own_kind [OWN_DEPS];
  int unsigned                 own_cnt;
  logic [PRED_SLOTS-1:0]       wait_bits;
  logic [PRED_SLOTS-1:0]       done_bits;
  tdhc_pkg::rsp_t              answers_due [$];

  function automatic logic [PRED_SLOTS-1:0] slot_onehot(
      input logic [tdhc_pkg::SLOT_W-1:0] slot);
    logic [PRED_SLOTS-1:0] bits;
    bits = '0;
    if (slot < PRED_SLOTS) bits[slot] = 1'b1;
    return bits;
  endfunction

  // Apply one request word to the shadow state and return the answer it earns
  function automatic tdhc_pkg::rsp_t hazard_answer(input tdhc_pkg::req_t w);
    tdhc_pkg::rsp_t              ans;
    logic [tdhc_pkg::ADDR_W-1:0] addr;
    ans  = '0;
    addr = w.dep_addr & ADDR_MASK;
    case (w.action)
      tdhc_pkg::ACT_CLEAR: begin
        own_cnt   = 0;
        wait_bits = '0;
      end
      tdhc_pkg::ACT_ADD: begin
        if (own_cnt < OWN_DEPS) begin
          own_addr[IW'(own_cnt)] = addr;
          own_kind[IW'(own_cnt)] = w.dep_kind;
          own_cnt++;
        end else begin
          ans.table_full = 1'b1;
        end
      end
      tdhc_pkg::ACT_CHECK: begin
        // two readers never clash; any other kind code counts as a writer
        for (int i = 0; i < own_cnt; i++)
          if (own_addr[IW'(i)] == addr &&
              !(own_kind[IW'(i)] == tdhc_pkg::KIND_IN && w.dep_kind == tdhc_pkg::KIND_IN))
            ans.conflict = 1'b1;
        if (ans.conflict) wait_bits |= slot_onehot(w.pred_slot);
      end
      tdhc_pkg::ACT_COMPLETE: done_bits |= slot_onehot(w.pred_slot);
      tdhc_pkg::ACT_RESTART:  done_bits &= ~slot_onehot(w.pred_slot);
      default: ;
    endcase
    ans.ready_res = ((wait_bits & ~done_bits) == '0);
    return ans;
  endfunction

  task automatic compare_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s expected %0b, got %0b", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    tdhc_pkg::rsp_t want;
    tdhc_pkg::rsp_t due;
    if (rst) begin
      own_cnt   = 0;
      wait_bits = '0;
      done_bits = '0;
      answers_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (answers_due.size() == 0) begin
          fail_count++;
          $display("%0t ns: result word expected none, got %b", $time, rsp);
        end else begin
          want = answers_due.pop_front();
          compare_field("conflict", want.conflict, rsp.conflict);
          compare_field("ready_res", want.ready_res, rsp.ready_res);
          compare_field("table_full", want.table_full, rsp.table_full);
        end
      end
      if (req_valid && !req_stall) begin
        due         = hazard_answer(req);
        answers_due = {answers_due, due};
      end
    end
    words_pending <= answers_due.size();
  end

endmodule

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OWN_DEPS     = 16;
  localparam int unsigned PRED_SLOTS   = 16;
  localparam int unsigned ADDR_BITS    = 48;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned POOL_N       = 6;
  localparam int unsigned POOL_IW      = $clog2(POOL_N);
  localparam int unsigned BIT_IW       = $clog2(tdhc_pkg::ADDR_W);
  localparam int unsigned HOLD_AT      = 200;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Action and kind codes the package leaves unnamed
  localparam logic [tdhc_pkg::ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
  localparam logic [tdhc_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [tdhc_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
  localparam logic [tdhc_pkg::KIND_W-1:0]   KIND_SPARE  = 2'd3;

  // Idle pattern: which side rests how often
  typedef enum int {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  tdhc_pkg::req_t req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  tdhc_pkg::rsp_t rsp;
  int unsigned    fail_count;
  int unsigned    words_pending;

  pace_t                       pace = PACE_RX_SLOW;
  logic                        holding = 1'b0;
  int unsigned                 words_sent = 0;
  int unsigned                 cycles = 0;
  logic [tdhc_pkg::ADDR_W-1:0] addr_pool [POOL_N];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task_dependence_hazard_checker_top #(
    .OWN_DEPS   (OWN_DEPS),
    .PRED_SLOTS (PRED_SLOTS),
    .ADDR_BITS  (ADDR_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  tdhc_checker #(
    .OWN_DEPS   (OWN_DEPS),
    .PRED_SLOTS (PRED_SLOTS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // Watchdog: end the run if the block hangs somewhere
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: stall at random per the current pace, or hard during the hold-off
  always @(posedge clk) begin
    if (holding) begin
      rsp_stall <= 1'b1;
    end else begin
      case (pace)
        PACE_RX_SLOW: rsp_stall <= ($urandom_range(0, 99) < 62);
        PACE_TX_SLOW: rsp_stall <= ($urandom_range(0, 99) < 37);
        default:      rsp_stall <= 1'b0;
      endcase
    end
  end

  // Hold off the receiver for a long stretch while the sender keeps offering,
  // so the result register fills and the block has to stall its input
  initial begin
    wait (words_sent >= HOLD_AT);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  function automatic bit sender_rests();
    case (pace)
      PACE_RX_SLOW: return $urandom_range(0, 99) < 37;
      PACE_TX_SLOW: return $urandom_range(0, 99) < 62;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic logic [tdhc_pkg::ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[tdhc_pkg::ADDR_W-1:0];
  endfunction

  // Mostly addresses from a small pool so that checks hit table entries;
  // now and then a fresh address or a one-bit near miss of a pool entry
  function automatic logic [tdhc_pkg::ADDR_W-1:0] pick_addr();
    logic [tdhc_pkg::ADDR_W-1:0] a;
    a = addr_pool[POOL_IW'($urandom_range(0, POOL_N-1))];
    case ($urandom_range(0, 9))
      0:       a = rand_addr();
      1:       a[BIT_IW'($urandom_range(0, tdhc_pkg::ADDR_W-1))] ^= 1'b1;
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [tdhc_pkg::KIND_W-1:0] rand_kind();
    logic [31:0] r;
    r = $urandom_range(0, 3);
    return r[tdhc_pkg::KIND_W-1:0];
  endfunction

  function automatic logic [tdhc_pkg::SLOT_W-1:0] rand_slot();
    logic [31:0] r;
    r = $urandom_range(0, 15);
    return r[tdhc_pkg::SLOT_W-1:0];
  endfunction

  function automatic logic [tdhc_pkg::ACTION_W-1:0] rand_action();
    logic [31:0] r;
    r = $urandom_range(0, 7);
    return r[tdhc_pkg::ACTION_W-1:0];
  endfunction

  // Offer one word; rest first if the pace says so, then hold it until taken.
  // Valid stays high from word to word when there is no rest in between.
  task automatic issue(input logic [tdhc_pkg::ACTION_W-1:0] act,
                       input logic [tdhc_pkg::KIND_W-1:0]   kind,
                       input logic [tdhc_pkg::ADDR_W-1:0]   addr,
                       input logic [tdhc_pkg::SLOT_W-1:0]   slot);
    tdhc_pkg::req_t w;
    w.action    = act;
    w.dep_kind  = kind;
    w.dep_addr  = addr;
    w.pred_slot = slot;
    while (sender_rests()) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    words_sent++;
  endtask

  // One task's life: usually a clear, a batch of own dependences (sometimes
  // past the table size), then checks mixed with slot completions and restarts
  task automatic run_task_sequence();
    int unsigned n_adds;
    int unsigned n_ops;
    if ($urandom_range(0, 4) != 0)
      issue(tdhc_pkg::ACT_CLEAR, rand_kind(), rand_addr(), rand_slot());
    n_adds = $urandom_range(0, OWN_DEPS + 2);
    repeat (n_adds) issue(tdhc_pkg::ACT_ADD, rand_kind(), pick_addr(), rand_slot());
    n_ops = $urandom_range(2, 12);
    repeat (n_ops) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: issue(tdhc_pkg::ACT_CHECK, rand_kind(), pick_addr(), rand_slot());
        5, 6:          issue(tdhc_pkg::ACT_COMPLETE, rand_kind(), pick_addr(), rand_slot());
        7:             issue(tdhc_pkg::ACT_RESTART, rand_kind(), pick_addr(), rand_slot());
        8:             issue(tdhc_pkg::ACT_ADD, rand_kind(), pick_addr(), rand_slot());
        default:       issue(rand_action(), rand_kind(), rand_addr(), rand_slot());
      endcase
    end
  endtask

  initial begin
    int unsigned start;
    for (int i = 0; i < POOL_N; i++) addr_pool[i] = rand_addr();
    addr_pool[0] = '1;
    addr_pool[1] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: check against an empty table
    issue(tdhc_pkg::ACT_CHECK, tdhc_pkg::KIND_OUT, addr_pool[2], 4'd3);
    // Fill the table with the address and kind extremes, then overflow it
    issue(tdhc_pkg::ACT_ADD, tdhc_pkg::KIND_IN, '1, 4'd0);
    issue(tdhc_pkg::ACT_ADD, tdhc_pkg::KIND_OUT, '0, 4'd15);
    issue(tdhc_pkg::ACT_ADD, tdhc_pkg::KIND_INOUT, addr_pool[2], 4'd0);
    issue(tdhc_pkg::ACT_ADD, KIND_SPARE, addr_pool[3], 4'd0);
    repeat (OWN_DEPS - 4) issue(tdhc_pkg::ACT_ADD, rand_kind(), rand_addr(), rand_slot());
    issue(tdhc_pkg::ACT_ADD, tdhc_pkg::KIND_OUT, addr_pool[4], 4'd0);
    // Reader against reader, writer against reader, spare kind, and a miss
    issue(tdhc_pkg::ACT_CHECK, tdhc_pkg::KIND_IN, '1, 4'd0);
    issue(tdhc_pkg::ACT_CHECK, tdhc_pkg::KIND_OUT, '1, 4'd15);
    issue(tdhc_pkg::ACT_CHECK, tdhc_pkg::KIND_IN, '0, 4'd1);
    issue(tdhc_pkg::ACT_CHECK, tdhc_pkg::KIND_IN, addr_pool[3], 4'd2);
    issue(tdhc_pkg::ACT_CHECK, KIND_SPARE, addr_pool[5], 4'd7);
    // Complete the waited-on slots, then restart one of them
    issue(tdhc_pkg::ACT_COMPLETE, tdhc_pkg::KIND_IN, '0, 4'd15);
    issue(tdhc_pkg::ACT_COMPLETE, tdhc_pkg::KIND_IN, '0, 4'd1);
    issue(tdhc_pkg::ACT_COMPLETE, tdhc_pkg::KIND_IN, '0, 4'd2);
    issue(tdhc_pkg::ACT_RESTART, tdhc_pkg::KIND_IN, '0, 4'd2);
    // Spare action codes leave the state alone
    issue(ACT_SPARE_5, tdhc_pkg::KIND_OUT, '1, 4'd2);
    issue(ACT_SPARE_6, tdhc_pkg::KIND_INOUT, '1, 4'd15);
    issue(ACT_SPARE_7, KIND_SPARE, '1, 4'd0);
    // Clear drops the table and the mask but keeps the done flags
    issue(tdhc_pkg::ACT_CLEAR, tdhc_pkg::KIND_IN, '0, 4'd0);

    // Random: three paces, each over about a third of the words
    start = words_sent;
    while (words_sent < start + RANDOM_ITEMS) begin
      if (words_sent >= start + 2 * RANDOM_ITEMS / 3) pace <= PACE_FULL;
      else if (words_sent >= start + RANDOM_ITEMS / 3) pace <= PACE_TX_SLOW;
      if ($urandom_range(0, 4) != 0) begin
        run_task_sequence();
      end else begin
        // noise: words with every field random
        repeat ($urandom_range(1, 6)) begin
          issue(rand_action(), rand_kind(), rand_addr(), rand_slot());
        end
      end
    end
    req_valid <= 1'b0;

    // Drain: wait for every result word, then keep watching for strays
    do @(posedge clk); while (words_pending != 0);
    repeat (OWN_DEPS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
